FILE: rtl/cstes_pkg.sv
// shared types, widths and constants of the triangle element stiffness block
package cstes_pkg;

   // default parameter values
   localparam int NODE_COUNT_DEF      = 1024;
   localparam int COORD_FRAC_BITS_DEF = 4;

   // field widths
   localparam int COORD_W  = 16;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int NODE_W   = 10;
   localparam int DOF_W    = NODE_W + 1;
   localparam int MAT_W    = 32;
   localparam int DET_W    = 33;
   localparam int VALUE_W  = 64;
   localparam int CSR_IDX_W = 3;

   // arithmetic widths of the entry pipeline
   localparam int U_W     = 2 * DIFF_W;
   localparam int W_W     = MAT_W + U_W;
   localparam int T_W     = W_W + 2;
   localparam int MAG_W   = 66;
   localparam int CHUNK_W = 22;
   localparam int DLO_W   = 17;
   localparam int DHI_W   = DET_W - DLO_W;
   localparam int PL_W    = CHUNK_W + DLO_W;
   localparam int PH_W    = CHUNK_W + DHI_W;
   localparam int R_W     = PH_W + DLO_W + 1;
   localparam int SUM_W   = 100;

   // queue depths
   localparam int ELEM_DEPTH = 2;
   localparam int OUT_DEPTH  = 16;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_D00 = 3'd0,
      CSR_D01 = 3'd1,
      CSR_D02 = 3'd2,
      CSR_D11 = 3'd3,
      CSR_D12 = 3'd4,
      CSR_D22 = 3'd5
   } csr_idx_type;

   // one classified element waiting for the back end
   typedef struct packed {
      logic [DIFF_W-1:0] dy0;
      logic [DIFF_W-1:0] dy1;
      logic [DIFF_W-1:0] dy2;
      logic [DIFF_W-1:0] dx0;
      logic [DIFF_W-1:0] dx1;
      logic [DIFF_W-1:0] dx2;
      logic [DET_W-1:0]  det_mag;
      logic [NODE_W-1:0] node0;
      logic [NODE_W-1:0] node1;
      logic [NODE_W-1:0] node2;
   } elem_type;

   // one finished stiffness entry
   typedef struct packed {
      logic [DOF_W-1:0]   dof_row;
      logic [DOF_W-1:0]   dof_col;
      logic [VALUE_W-1:0] stiff_value;
      logic               last_entry;
   } rsp_type;

   // tag travelling with an entry down the pipeline
   typedef struct packed {
      logic [DOF_W-1:0] dof_row;
      logic [DOF_W-1:0] dof_col;
      logic             last_entry;
      logic [DET_W-1:0] det_mag;
   } side_type;

endpackage

FILE: rtl/cstes_queue.sv
// small first-in first-out queue of flat words
module cstes_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: rtl/cstes_front.sv
// front end: takes triangle items, forms edge differences, area and node clamps
module cstes_front #(
   parameter int NODE_COUNT = cstes_pkg::NODE_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic signed [cstes_pkg::COORD_W-1:0] p0_x,
   input  logic signed [cstes_pkg::COORD_W-1:0] p0_y,
   input  logic signed [cstes_pkg::COORD_W-1:0] p1_x,
   input  logic signed [cstes_pkg::COORD_W-1:0] p1_y,
   input  logic signed [cstes_pkg::COORD_W-1:0] p2_x,
   input  logic signed [cstes_pkg::COORD_W-1:0] p2_y,
   input  logic        [cstes_pkg::NODE_W-1:0]  p0_node,
   input  logic        [cstes_pkg::NODE_W-1:0]  p1_node,
   input  logic        [cstes_pkg::NODE_W-1:0]  p2_node,
   output logic                                q_push,
   output cstes_pkg::elem_type                 q_elem,
   input  logic                                q_full
);

   localparam int CW = cstes_pkg::COORD_W;
   localparam int DW = cstes_pkg::DIFF_W;
   localparam int NW = cstes_pkg::NODE_W;
   localparam int PW = 2 * DW;
   localparam logic [NW-1:0] NODE_MAX = NW'(NODE_COUNT - 1);

   logic               valid_ff, valid_in;
   logic               accept;
   logic [CW-1:0]      x0_ff, y0_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic [NW-1:0]      n0_ff, n1_ff, n2_ff;
   logic signed [DW-1:0] dy0, dy1, dy2, dx0, dx1, dx2;
   logic signed [PW-1:0] cross_a, cross_b;
   logic signed [PW:0]   det;
   logic [PW:0]          det_abs;

   assign full   = valid_ff && q_full;
   assign accept = push && !full;
   assign q_push = valid_ff && !q_full;

   // holding register for the accepted item
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x0_ff <= p0_x;
         y0_ff <= p0_y;
         x1_ff <= p1_x;
         y1_ff <= p1_y;
         x2_ff <= p2_x;
         y2_ff <= p2_y;
         n0_ff <= p0_node;
         n1_ff <= p1_node;
         n2_ff <= p2_node;
      end
   end

   // edge differences of the strain matrix
   assign dy0 = $signed({y1_ff[CW-1], y1_ff}) - $signed({y2_ff[CW-1], y2_ff});
   assign dy1 = $signed({y2_ff[CW-1], y2_ff}) - $signed({y0_ff[CW-1], y0_ff});
   assign dy2 = $signed({y0_ff[CW-1], y0_ff}) - $signed({y1_ff[CW-1], y1_ff});
   assign dx0 = $signed({x2_ff[CW-1], x2_ff}) - $signed({x1_ff[CW-1], x1_ff});
   assign dx1 = $signed({x0_ff[CW-1], x0_ff}) - $signed({x2_ff[CW-1], x2_ff});
   assign dx2 = $signed({x1_ff[CW-1], x1_ff}) - $signed({x0_ff[CW-1], x0_ff});

   // twice the signed area and its magnitude
   assign cross_a = dx2 * dy1;
   assign cross_b = dx1 * dy2;
   assign det     = $signed({cross_a[PW-1], cross_a}) - $signed({cross_b[PW-1], cross_b});
   assign det_abs = det[PW] ? (~det + 1'b1) : det;

   // element record with clamped node numbers
   always_comb begin
      q_elem         = '0;
      q_elem.dy0     = dy0;
      q_elem.dy1     = dy1;
      q_elem.dy2     = dy2;
      q_elem.dx0     = dx0;
      q_elem.dx1     = dx1;
      q_elem.dx2     = dx2;
      q_elem.det_mag = det_abs[cstes_pkg::DET_W-1:0];
      q_elem.node0   = (32'(n0_ff) >= 32'(NODE_COUNT)) ? NODE_MAX : n0_ff;
      q_elem.node1   = (32'(n1_ff) >= 32'(NODE_COUNT)) ? NODE_MAX : n1_ff;
      q_elem.node2   = (32'(n2_ff) >= 32'(NODE_COUNT)) ? NODE_MAX : n2_ff;
   end

endmodule

FILE: rtl/cstes_back.sv
// back end: walks the 36 entries of an element through the product pipeline
module cstes_back #(
   parameter int COORD_FRAC_BITS = cstes_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [cstes_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cstes_pkg::MAT_W-1:0]           csr_wdata,
   input  cstes_pkg::elem_type                   q_elem,
   input  logic                                  q_empty,
   output logic                                  q_pop,
   input  logic                                  pop,
   output logic                                  empty,
   output cstes_pkg::rsp_type                    rsp
);

   localparam int DW    = cstes_pkg::DIFF_W;
   localparam int MW    = cstes_pkg::MAT_W;
   localparam int UW    = cstes_pkg::U_W;
   localparam int WW    = cstes_pkg::W_W;
   localparam int TW    = cstes_pkg::T_W;
   localparam int GW    = cstes_pkg::MAG_W;
   localparam int CKW   = cstes_pkg::CHUNK_W;
   localparam int DLW   = cstes_pkg::DLO_W;
   localparam int DHW   = cstes_pkg::DHI_W;
   localparam int PLW   = cstes_pkg::PL_W;
   localparam int PHW   = cstes_pkg::PH_W;
   localparam int RW    = cstes_pkg::R_W;
   localparam int SW    = cstes_pkg::SUM_W;
   localparam int VW    = cstes_pkg::VALUE_W;
   localparam int SHIFT = 4 * COORD_FRAC_BITS + 1;
   localparam int ODEP  = cstes_pkg::OUT_DEPTH;
   localparam int OCW   = $clog2(ODEP + 1);
   localparam logic [SW-1:0] HALF    = SW'(1) << (SHIFT - 1);
   localparam logic [SW-1:0] POS_LIM = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
   localparam logic [SW-1:0] NEG_LIM = {{(SW-VW){1'b0}}, 1'b1, {(VW-1){1'b0}}};

   // material registers
   logic signed [MW-1:0] d00_ff, d01_ff, d02_ff, d11_ff, d12_ff, d22_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d00_ff <= '0;
         d01_ff <= '0;
         d02_ff <= '0;
         d11_ff <= '0;
         d12_ff <= '0;
         d22_ff <= '0;
      end else if (csr_valid) begin
         unique case (cstes_pkg::csr_idx_type'(csr_index))
            cstes_pkg::CSR_D00: d00_ff <= csr_wdata;
            cstes_pkg::CSR_D01: d01_ff <= csr_wdata;
            cstes_pkg::CSR_D02: d02_ff <= csr_wdata;
            cstes_pkg::CSR_D11: d11_ff <= csr_wdata;
            cstes_pkg::CSR_D12: d12_ff <= csr_wdata;
            cstes_pkg::CSR_D22: d22_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // entry sequencer: row vertex, column vertex, row axis, column axis
   logic [1:0] r_ff, r_in, c_ff, c_in;
   logic       ar_ff, ar_in, ac_ff, ac_in;
   logic [OCW-1:0] owed_ff, owed_in;
   logic       issue, is_last, out_push, out_full, do_pop;

   assign is_last = (r_ff == 2'd2) && (c_ff == 2'd2) && ar_ff && ac_ff;
   assign issue   = !q_empty && (owed_ff < OCW'(ODEP));
   assign q_pop   = issue && is_last;
   assign do_pop  = pop && !empty;

   always_comb begin
      r_in  = r_ff;
      c_in  = c_ff;
      ar_in = ar_ff;
      ac_in = ac_ff;
      if (issue) begin
         ac_in = !ac_ff;
         if (ac_ff) begin
            ar_in = !ar_ff;
            if (ar_ff) begin
               c_in = (c_ff == 2'd2) ? 2'd0 : c_ff + 2'd1;
               if (c_ff == 2'd2) begin
                  r_in = (r_ff == 2'd2) ? 2'd0 : r_ff + 2'd1;
               end
            end
         end
      end
      owed_in = owed_ff;
      if (issue && !do_pop) begin
         owed_in = owed_ff + 1'b1;
      end else if (do_pop && !issue) begin
         owed_in = owed_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff    <= '0;
         c_ff    <= '0;
         ar_ff   <= 1'b0;
         ac_ff   <= 1'b0;
         owed_ff <= '0;
      end else begin
         r_ff    <= r_in;
         c_ff    <= c_in;
         ar_ff   <= ar_in;
         ac_ff   <= ac_in;
         owed_ff <= owed_in;
      end
   end

   // pick the nonzero strain terms of the row and column and their material entries
   logic signed [DW-1:0] dy_r, dx_r, dy_c, dx_c;
   logic [cstes_pkg::NODE_W-1:0] node_r, node_c;
   logic signed [DW-1:0] pa_in, pb_in, qa_in, qb_in;
   logic signed [MW-1:0] daa_in, dab_in, dba_in;
   cstes_pkg::side_type  side_in;

   always_comb begin
      case (r_ff)
         2'd0:    begin dy_r = q_elem.dy0; dx_r = q_elem.dx0; node_r = q_elem.node0; end
         2'd1:    begin dy_r = q_elem.dy1; dx_r = q_elem.dx1; node_r = q_elem.node1; end
         default: begin dy_r = q_elem.dy2; dx_r = q_elem.dx2; node_r = q_elem.node2; end
      endcase
      case (c_ff)
         2'd0:    begin dy_c = q_elem.dy0; dx_c = q_elem.dx0; node_c = q_elem.node0; end
         2'd1:    begin dy_c = q_elem.dy1; dx_c = q_elem.dx1; node_c = q_elem.node1; end
         default: begin dy_c = q_elem.dy2; dx_c = q_elem.dx2; node_c = q_elem.node2; end
      endcase
      pa_in = ar_ff ? dx_r : dy_r;
      pb_in = ar_ff ? dy_r : dx_r;
      qa_in = ac_ff ? dx_c : dy_c;
      qb_in = ac_ff ? dy_c : dx_c;
      case ({ar_ff, ac_ff})
         2'b00:   daa_in = d00_ff;
         2'b11:   daa_in = d11_ff;
         default: daa_in = d01_ff;
      endcase
      dab_in = ar_ff ? d12_ff : d02_ff;
      dba_in = ac_ff ? d12_ff : d02_ff;
      side_in.dof_row    = {node_r, ar_ff};
      side_in.dof_col    = {node_c, ac_ff};
      side_in.last_entry = is_last;
      side_in.det_mag    = q_elem.det_mag;
   end

   // pipeline valid bits
   logic [6:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[5:0], issue};
      end
   end

   // stage 1: selected operands
   logic signed [DW-1:0] pa_ff, pb_ff, qa_ff, qb_ff;
   logic signed [MW-1:0] daa_ff, dab_ff, dba_ff, dbb_ff;
   cstes_pkg::side_type  s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   logic                 l6_ff, l7_ff;
   logic [cstes_pkg::DOF_W-1:0] row6_ff, col6_ff, row7_ff, col7_ff;

   always_ff @(posedge clock) begin
      if (issue) begin
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         qa_ff  <= qa_in;
         qb_ff  <= qb_in;
         daa_ff <= daa_in;
         dab_ff <= dab_in;
         dba_ff <= dba_in;
         dbb_ff <= d22_ff;
         s1_ff  <= side_in;
      end
   end

   // stage 2: products of strain terms
   logic signed [UW-1:0] uaa_ff, uab_ff, uba_ff, ubb_ff;
   logic signed [MW-1:0] eaa_ff, eab_ff, eba_ff, ebb_ff;

   always_ff @(posedge clock) begin
      uaa_ff <= pa_ff * qa_ff;
      uab_ff <= pa_ff * qb_ff;
      uba_ff <= pb_ff * qa_ff;
      ubb_ff <= pb_ff * qb_ff;
      eaa_ff <= daa_ff;
      eab_ff <= dab_ff;
      eba_ff <= dba_ff;
      ebb_ff <= dbb_ff;
      s2_ff  <= s1_ff;
   end

   // stage 3: weighted by the material entries
   logic signed [WW-1:0] waa_ff, wab_ff, wba_ff, wbb_ff;

   always_ff @(posedge clock) begin
      waa_ff <= eaa_ff * uaa_ff;
      wab_ff <= eab_ff * uab_ff;
      wba_ff <= eba_ff * uba_ff;
      wbb_ff <= ebb_ff * ubb_ff;
      s3_ff  <= s2_ff;
   end

   // stage 4: quadratic form and its magnitude
   logic signed [TW-1:0] t_sum;
   logic [TW-1:0]        t_abs;
   logic [GW-1:0]        mag_ff;
   logic                 neg4_ff, neg5_ff, neg6_ff, neg7_ff;

   assign t_sum = TW'(waa_ff) + TW'(wab_ff) + TW'(wba_ff) + TW'(wbb_ff);
   assign t_abs = t_sum[TW-1] ? (~t_sum + 1'b1) : t_sum;

   always_ff @(posedge clock) begin
      mag_ff  <= t_abs[GW-1:0];
      neg4_ff <= t_sum[TW-1];
      s4_ff   <= s3_ff;
   end

   // stage 5: partial products of magnitude and area
   logic [DLW-1:0] det_lo;
   logic [DHW-1:0] det_hi;
   logic [PLW-1:0] pl0_ff, pl1_ff, pl2_ff;
   logic [PHW-1:0] ph0_ff, ph1_ff, ph2_ff;

   assign det_lo = s4_ff.det_mag[DLW-1:0];
   assign det_hi = s4_ff.det_mag[cstes_pkg::DET_W-1:DLW];

   always_ff @(posedge clock) begin
      pl0_ff  <= mag_ff[CKW-1:0] * det_lo;
      pl1_ff  <= mag_ff[2*CKW-1:CKW] * det_lo;
      pl2_ff  <= mag_ff[3*CKW-1:2*CKW] * det_lo;
      ph0_ff  <= mag_ff[CKW-1:0] * det_hi;
      ph1_ff  <= mag_ff[2*CKW-1:CKW] * det_hi;
      ph2_ff  <= mag_ff[3*CKW-1:2*CKW] * det_hi;
      neg5_ff <= neg4_ff;
      s5_ff   <= s4_ff;
   end

   // stage 6: one column per magnitude chunk
   logic [RW-1:0] r0_ff, r1_ff, r2_ff;

   always_ff @(posedge clock) begin
      r0_ff   <= RW'(pl0_ff) + (RW'(ph0_ff) << DLW);
      r1_ff   <= RW'(pl1_ff) + (RW'(ph1_ff) << DLW);
      r2_ff   <= RW'(pl2_ff) + (RW'(ph2_ff) << DLW);
      neg6_ff <= neg5_ff;
      row6_ff <= s5_ff.dof_row;
      col6_ff <= s5_ff.dof_col;
      l6_ff   <= s5_ff.last_entry;
   end

   // stage 7: full product with rounding offset
   logic [SW-1:0] sum_ff;

   always_ff @(posedge clock) begin
      sum_ff  <= SW'(r0_ff) + (SW'(r1_ff) << CKW) + (SW'(r2_ff) << (2 * CKW)) + HALF;
      neg7_ff <= neg6_ff;
      row7_ff <= row6_ff;
      col7_ff <= col6_ff;
      l7_ff   <= l6_ff;
   end

   // scale down, restore sign and saturate
   logic [SW-1:0]       scaled;
   logic [VW-1:0]       value;
   cstes_pkg::rsp_type  out_word;

   assign scaled = sum_ff >> SHIFT;

   always_comb begin
      if (neg7_ff) begin
         value = (scaled > NEG_LIM) ? NEG_LIM[VW-1:0] : (~scaled[VW-1:0] + 1'b1);
      end else begin
         value = (scaled > POS_LIM) ? POS_LIM[VW-1:0] : scaled[VW-1:0];
      end
      out_word.dof_row     = row7_ff;
      out_word.dof_col     = col7_ff;
      out_word.stiff_value = value;
      out_word.last_entry  = l7_ff;
   end

   assign out_push = v_ff[6];

   // result queue, sized to absorb every entry in flight
   logic [$bits(cstes_pkg::rsp_type)-1:0] out_rdata;

   cstes_queue #(
      .WIDTH ($bits(cstes_pkg::rsp_type)),
      .DEPTH (ODEP)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_word),
      .full  (out_full),
      .pop   (pop),
      .rdata (out_rdata),
      .empty (empty)
   );

   assign rsp = cstes_pkg::rsp_type'(out_rdata);

   // the credit count keeps the result queue from overflowing
   logic unused_full;
   assign unused_full = out_full;

endmodule

FILE: rtl/cst_element_stiffness_top.sv
// top level of the triangle element stiffness block
//
//  channel   | handshake            | carries
//  ----------+----------------------+-------------------------------------------
//  req       | push / full          | three vertex coordinates, three node numbers
//  rsp       | pop / empty          | dof row, dof column, stiffness value, last flag
//  csr       | csr_valid / csr_ready| register index and 32-bit material entry
//
//  one element gives 36 entries, one per cycle from the back-end sequencer while
//  an element is queued and fewer than 16 entries are owed to the result side;
//  each entry passes through the seven-stage product pipeline to the result queue.
//  reset is synchronous and clears queues, sequencer and material registers.
//  a stalled result side fills the 16-entry result queue, then the sequencer holds,
//  then the two-element queue and the input register fill and full rises.
module cst_element_stiffness_top #(
   parameter int NODE_COUNT      = cstes_pkg::NODE_COUNT_DEF,
   parameter int COORD_FRAC_BITS = cstes_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   output logic                                   full,
   input  logic signed [cstes_pkg::COORD_W-1:0]   req_p0_x,
   input  logic signed [cstes_pkg::COORD_W-1:0]   req_p0_y,
   input  logic signed [cstes_pkg::COORD_W-1:0]   req_p1_x,
   input  logic signed [cstes_pkg::COORD_W-1:0]   req_p1_y,
   input  logic signed [cstes_pkg::COORD_W-1:0]   req_p2_x,
   input  logic signed [cstes_pkg::COORD_W-1:0]   req_p2_y,
   input  logic        [cstes_pkg::NODE_W-1:0]    req_p0_node,
   input  logic        [cstes_pkg::NODE_W-1:0]    req_p1_node,
   input  logic        [cstes_pkg::NODE_W-1:0]    req_p2_node,
   output logic                                   empty,
   input  logic                                   pop,
   output logic        [cstes_pkg::DOF_W-1:0]     rsp_dof_row,
   output logic        [cstes_pkg::DOF_W-1:0]     rsp_dof_col,
   output logic signed [cstes_pkg::VALUE_W-1:0]   rsp_stiff_value,
   output logic                                   rsp_last_entry,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [cstes_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [cstes_pkg::MAT_W-1:0]     csr_wdata
);

   cstes_pkg::elem_type fe_elem, be_elem;
   cstes_pkg::rsp_type  rsp;
   logic fe_push, fe_full, be_empty, be_pop;
   logic [$bits(cstes_pkg::elem_type)-1:0] be_word;

   assign csr_ready = 1'b1;

   // front end
   cstes_front #(
      .NODE_COUNT (NODE_COUNT)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .p0_x    (req_p0_x),
      .p0_y    (req_p0_y),
      .p1_x    (req_p1_x),
      .p1_y    (req_p1_y),
      .p2_x    (req_p2_x),
      .p2_y    (req_p2_y),
      .p0_node (req_p0_node),
      .p1_node (req_p1_node),
      .p2_node (req_p2_node),
      .q_push  (fe_push),
      .q_elem  (fe_elem),
      .q_full  (fe_full)
   );

   // element queue between the two halves
   cstes_queue #(
      .WIDTH ($bits(cstes_pkg::elem_type)),
      .DEPTH (cstes_pkg::ELEM_DEPTH)
   ) u_elem_queue (
      .clock (clock),
      .reset (reset),
      .push  (fe_push),
      .wdata (fe_elem),
      .full  (fe_full),
      .pop   (be_pop),
      .rdata (be_word),
      .empty (be_empty)
   );

   assign be_elem = cstes_pkg::elem_type'(be_word);

   // back end
   cstes_back #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_elem    (be_elem),
      .q_empty   (be_empty),
      .q_pop     (be_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp       (rsp)
   );

   assign rsp_dof_row     = rsp.dof_row;
   assign rsp_dof_col     = rsp.dof_col;
   assign rsp_stiff_value = rsp.stiff_value;
   assign rsp_last_entry  = rsp.last_entry;

endmodule
